// ===== hw/rtl/rlcg_pkg.sv =====
// shared types and constants for the rgb lookup table color grading block
`default_nettype none

package rlcg_pkg;

  // one color channel and the fixed port widths
  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 3;
  localparam int LOAD_ADDR_W = 15;

  // blend strength register
  localparam int           CFG_W         = 9;
  localparam logic [8:0]   CFG_RESET_VAL = 9'd256;

  // input action codes
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_LOAD  = 1'b1;

  // one color, index 0 red (lowest bits), 1 green, 2 blue
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgb_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rlcg_ram.sv =====
// generic single-port ram with registered read data
`default_nettype none

module rlcg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read data only changes on a read, so it holds across writes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rlcg_blend.sv =====
// two-stage blend of original and table colors: multiply, then add and scale
`default_nettype none

module rlcg_blend import rlcg_pkg::*; #(
  parameter int STRENGTH_FRAC_BITS = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire rgb_t             orig_i,
  input  wire rgb_t             table_i,
  input  wire logic             eof_i,
  input  wire logic [CFG_W-1:0] strength_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      rgb_t             out_color_o,
  output      logic             out_eof_o
);

  localparam int WtW   = STRENGTH_FRAC_BITS + 1;
  localparam int ProdW = CHAN_W + WtW;
  localparam int CmpW  = (CFG_W > WtW) ? CFG_W : WtW;

  // strength clamp to one
  logic [CmpW-1:0] str_ext, one_ext;
  logic [WtW-1:0]  s_eff, s_inv;

  assign str_ext = CmpW'(strength_i);
  assign one_ext = CmpW'(1) << STRENGTH_FRAC_BITS;
  assign s_eff   = (str_ext > one_ext) ? WtW'(one_ext) : WtW'(str_ext);
  assign s_inv   = WtW'(one_ext) - s_eff;

  // multiply stage
  logic                           s2_valid_q, s2_valid_d;
  logic                           s2_ready;
  logic [NUM_CHAN-1:0][ProdW-1:0] prod_orig_q, prod_orig_d;
  logic [NUM_CHAN-1:0][ProdW-1:0] prod_tab_q, prod_tab_d;
  logic                           s2_eof_q;

  // add and output stage
  logic        s3_valid_q, s3_valid_d;
  logic        s3_ready;
  rgb_t        color_q, color_d;
  logic        s3_eof_q;

  logic [NUM_CHAN-1:0][ProdW-1:0] sum;

  assign s3_ready   = !s3_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign in_ready_o = s2_ready;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      prod_orig_d[c] = ProdW'(orig_i[c]) * ProdW'(s_inv);
      prod_tab_d[c]  = ProdW'(table_i[c]) * ProdW'(s_eff);
      sum[c]         = prod_orig_q[c] + prod_tab_q[c];
      color_d[c]     = sum[c][STRENGTH_FRAC_BITS +: CHAN_W];
    end
  end

  assign s2_valid_d = s2_ready ? in_valid_i : s2_valid_q;
  assign s3_valid_d = s3_ready ? s2_valid_q : s3_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
      s3_valid_q <= s3_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && in_valid_i) begin
      prod_orig_q <= prod_orig_d;
      prod_tab_q  <= prod_tab_d;
      s2_eof_q    <= eof_i;
    end
    if (s3_ready && s2_valid_q) begin
      color_q  <= color_d;
      s3_eof_q <= s2_eof_q;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_color_o = color_q;
  assign out_eof_o   = s3_eof_q;

  // a stalled product stage keeps its products
  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s3_ready) |=> (s2_valid_q && $stable(prod_orig_q) && $stable(prod_tab_q)))
    else $error("product stage changed while stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_lut_color_grade.sv =====
// top level of the rgb lookup table color grading pipeline
//
// usage:
//   input channel (in_valid_i / in_ready_o) carries one request per item.
//   action_i = pixel grades red/green/blue through the table and gives one
//   result on the output channel, with end_of_frame copied along.
//   action_i = load writes load_red/green/blue into the table entry at
//   load_address_i and gives no result. table entries must be loaded
//   before pixels that hit them; reset does not touch the table.
//   config channel (cfg_valid_i / cfg_ready_o) writes blend_strength, always
//   ready; write it only while the pipeline is empty. values above one
//   (1 << STRENGTH_FRAC_BITS) act as one.
//   path: a pixel passes the table read register, then the multiply, then
//   the add and scale registers before it shows on the output.
//   throughput: while in_ready_o is high, one request per clock, loads and
//   pixels alike; the single table port serves one read or one write per cycle.
//   reset clears all valid bits and sets blend_strength to one.
//   when the receiver stalls, the stages fill up and in_ready_o drops; no
//   request is lost or repeated.
`default_nettype none

module rgb_lut_color_grade import rlcg_pkg::*; #(
  parameter int INDEX_BITS_PER_CHANNEL = 5,
  parameter int STRENGTH_FRAC_BITS     = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // pixel and load requests
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire logic                   action_i,
  input  wire logic [CHAN_W-1:0]      red_i,
  input  wire logic [CHAN_W-1:0]      green_i,
  input  wire logic [CHAN_W-1:0]      blue_i,
  input  wire logic                   end_of_frame_i,
  input  wire logic [LOAD_ADDR_W-1:0] load_address_i,
  input  wire logic [CHAN_W-1:0]      load_red_i,
  input  wire logic [CHAN_W-1:0]      load_green_i,
  input  wire logic [CHAN_W-1:0]      load_blue_i,
  // graded pixels
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      logic [CHAN_W-1:0]      out_red_o,
  output      logic [CHAN_W-1:0]      out_green_o,
  output      logic [CHAN_W-1:0]      out_blue_o,
  output      logic                   out_end_of_frame_o,
  // blend strength write
  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic [CFG_W-1:0]       cfg_blend_strength_i
);

  localparam int AddrW = 3 * INDEX_BITS_PER_CHANNEL;
  localparam int Depth = 1 << AddrW;
  localparam int RgbW  = NUM_CHAN * CHAN_W;

  // blend strength register
  logic [CFG_W-1:0] strength_q, strength_d;

  assign cfg_ready_o = 1'b1;
  assign strength_d  = (cfg_valid_i && cfg_ready_o) ? cfg_blend_strength_i : strength_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= CFG_RESET_VAL;
    end else begin
      strength_q <= strength_d;
    end
  end

  // request acceptance
  logic in_accept;
  logic blend_ready;
  logic s1_valid_q, s1_valid_d;

  assign in_ready_o = !s1_valid_q || blend_ready;
  assign in_accept  = in_valid_i && in_ready_o;

  // table index: top bits of each channel, red lowest, blue highest
  logic [AddrW-1:0] pix_addr, load_addr, ram_addr;
  rgb_t             load_color;
  rgb_t             ram_rdata;

  assign pix_addr  = {blue_i[CHAN_W-1 -: INDEX_BITS_PER_CHANNEL],
                      green_i[CHAN_W-1 -: INDEX_BITS_PER_CHANNEL],
                      red_i[CHAN_W-1 -: INDEX_BITS_PER_CHANNEL]};
  assign load_addr = AddrW'(load_address_i);
  assign ram_addr  = (action_i == ACT_LOAD) ? load_addr : pix_addr;

  assign load_color[0] = load_red_i;
  assign load_color[1] = load_green_i;
  assign load_color[2] = load_blue_i;

  // loads and pixel reads share the one port in request order, so a pixel
  // always sees every load accepted before it
  rlcg_ram #(
    .WIDTH (RgbW),
    .DEPTH (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .en_i    (in_accept),
    .we_i    (action_i == ACT_LOAD),
    .addr_i  (ram_addr),
    .wdata_i (load_color),
    .rdata_o (ram_rdata)
  );

  // table read stage: original pixel travels beside the read data
  rgb_t s1_orig_q;
  logic s1_eof_q;

  assign s1_valid_d = in_ready_o ? (in_accept && (action_i == ACT_PIXEL)) : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && (action_i == ACT_PIXEL)) begin
      s1_orig_q[0] <= red_i;
      s1_orig_q[1] <= green_i;
      s1_orig_q[2] <= blue_i;
      s1_eof_q     <= end_of_frame_i;
    end
  end

  // multiply and add stages, output register
  rgb_t out_color;

  rlcg_blend #(
    .STRENGTH_FRAC_BITS (STRENGTH_FRAC_BITS)
  ) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (blend_ready),
    .orig_i      (s1_orig_q),
    .table_i     (ram_rdata),
    .eof_i       (s1_eof_q),
    .strength_i  (strength_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_color_o (out_color),
    .out_eof_o   (out_end_of_frame_o)
  );

  assign out_red_o   = out_color[0];
  assign out_green_o = out_color[1];
  assign out_blue_o  = out_color[2];

  // a load never enters the blend path
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (action_i == ACT_LOAD)) |=> !s1_valid_q)
    else $error("load request produced a pixel in the read stage");

  // every accepted pixel lands in the read stage
  a_pixel_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (action_i == ACT_PIXEL)) |=> s1_valid_q)
    else $error("accepted pixel missing from the read stage");

  // a stalled read stage keeps its pixel and its table data
  a_read_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !blend_ready) |=>
      (s1_valid_q && $stable(s1_orig_q) && $stable(ram_rdata)))
    else $error("read stage changed while stalled");

endmodule

`default_nettype wire
